// ----- sv/bfns_pkg.sv -----
`timescale 1ns / 1ps

package bfns_pkg;

   // Field widths of the request and response words
   localparam int CMD_W   = 2;
   localparam int INDEX_W = 11;
   localparam int FOUND_W = 10;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TEST  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FIND  = 2'd2;

   // Reciprocal shift for splitting an index into word and offset
   localparam int RECIP_SH = 17;
   localparam int PROD_W   = 28;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_SPLIT,
      ST_WORD,
      ST_DONE
   } state_type;

endpackage

// ----- sv/bitset_find_next_set.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// req_      in         req_valid / req_stall   req_cmd, req_bit_index, req_bit_value
// rsp_      out        rsp_valid / rsp_stall   rsp_tested_bit, rsp_found, rsp_found_index
//
// rsp_valid rises once the request has passed ST_DIV, ST_SPLIT, ST_WORD and ST_DONE
// for an in-range write or test; find stays in ST_WORD while stored words are scanned
// (at most NUM_WORDS), one word per cycle through the single read port of the word memory,
// and an out-of-range request or an unused command skips ST_WORD.
// The next request is taken in the cycle after the result is loaded.
// After reset a clearing pass zeroes the word memory, one word a cycle;
// no request is taken meanwhile.
// One request is in flight at a time; a finished result waits in the output
// register while the next request is accepted, and rsp_stall holds it there.

module bitset_find_next_set #(
   parameter int NBITS     = 1024,
   parameter int WORD_BITS = 32,
   parameter int NUM_WORDS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [bfns_pkg::CMD_W-1:0]      req_cmd,
   input  logic signed [bfns_pkg::INDEX_W-1:0] req_bit_index,
   input  logic                            req_bit_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_tested_bit,
   output logic                            rsp_found,
   output logic [bfns_pkg::FOUND_W-1:0]    rsp_found_index
);

   localparam int AW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int CW    = $clog2(NUM_WORDS + 1);
   localparam int OW    = $clog2(WORD_BITS);
   localparam int IW    = bfns_pkg::INDEX_W;
   localparam int FW    = bfns_pkg::FOUND_W;
   localparam int RECIP = (2 ** bfns_pkg::RECIP_SH + WORD_BITS - 1) / WORD_BITS;
   localparam logic [CW-1:0] LAST_WORD = CW'(NUM_WORDS - 1);
   localparam logic [FW-1:0] WB_LOW    = FW'(WORD_BITS);

   bfns_pkg::state_type state_ff, state_in;

   logic [bfns_pkg::CMD_W-1:0] cmd_ff, cmd_in;
   logic                       val_ff, val_in;
   logic                       neg_ff, neg_in;
   logic [IW-1:0]              op_ff, op_in;
   logic [IW-1:0]              q_ff, q_in;
   logic [CW-1:0]              addr_ff, addr_in;
   logic [OW-1:0]              off_ff, off_in;
   logic [CW-1:0]              clr_ff, clr_in;
   logic                       res_tested_ff, res_tested_in;
   logic                       res_found_ff, res_found_in;
   logic [FW-1:0]              res_index_ff, res_index_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_tested_ff, rsp_tested_in;
   logic                       rsp_found_ff, rsp_found_in;
   logic [FW-1:0]              rsp_index_ff, rsp_index_in;

   // Word memory
   logic [WORD_BITS-1:0] mem [NUM_WORDS];
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   // Datapath helpers
   logic [bfns_pkg::PROD_W-1:0] prod;
   logic [IW-1:0]               rem;
   logic [CW-1:0]               addr_nx;
   logic [WORD_BITS-1:0]        bit_mask;
   logic                        scan_hit;
   logic [OW-1:0]               scan_pos;
   logic                        in_range;

   // Advance the clearing counter
   function automatic logic [CW-1:0] addr_nx_clr(input logic [CW-1:0] cnt);
      addr_nx_clr = cnt + {{(CW-1){1'b0}}, 1'b1};
   endfunction

   assign prod     = bfns_pkg::PROD_W'(op_ff) * bfns_pkg::PROD_W'(RECIP);
   assign rem      = op_ff - IW'(32'(q_ff) * WORD_BITS);
   assign addr_nx  = addr_ff + {{(CW-1){1'b0}}, 1'b1};
   assign bit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << off_ff;
   assign in_range = (32'(q_ff) < NUM_WORDS);

   bfns_scan #(
      .WORD_BITS (WORD_BITS),
      .OW        (OW)
   ) u_scan (
      .scan_word (rd_data_ff),
      .scan_from (off_ff),
      .scan_hit  (scan_hit),
      .scan_pos  (scan_pos)
   );

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfns_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and result payload
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      val_ff        <= val_in;
      neg_ff        <= neg_in;
      op_ff         <= op_in;
      q_ff          <= q_in;
      addr_ff       <= addr_in;
      off_ff        <= off_in;
      res_tested_ff <= res_tested_in;
      res_found_ff  <= res_found_in;
      res_index_ff  <= res_index_in;
      rsp_tested_ff <= rsp_tested_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_index_ff  <= rsp_index_in;
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      val_in        = val_ff;
      neg_in        = neg_ff;
      op_in         = op_ff;
      q_in          = q_ff;
      addr_in       = addr_ff;
      off_in        = off_ff;
      clr_in        = clr_ff;
      res_tested_in = res_tested_ff;
      res_found_in  = res_found_ff;
      res_index_in  = res_index_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_tested_in = rsp_tested_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_index_in  = rsp_index_ff;
      rd_en         = 1'b0;
      rd_addr       = addr_ff[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = addr_ff[AW-1:0];
      wr_data       = rd_data_ff;
      req_stall     = (state_ff != bfns_pkg::ST_IDLE);

      case (state_ff)
         // Zero the memory one word a cycle
         bfns_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff[AW-1:0];
            wr_data = '0;
            clr_in  = addr_nx_clr(clr_ff);
            if (clr_ff == LAST_WORD) begin
               state_in = bfns_pkg::ST_IDLE;
            end
         end

         // Take a request word; find starts one above the index, or at zero if it is negative
         bfns_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd_in = req_cmd;
               val_in = req_bit_value;
               neg_in = req_bit_index[IW-1];
               if (req_cmd == bfns_pkg::CMD_FIND) begin
                  op_in = req_bit_index[IW-1] ? '0 :
                          IW'(req_bit_index) + {{(IW-1){1'b0}}, 1'b1};
               end else begin
                  op_in = IW'(req_bit_index);
               end
               state_in = bfns_pkg::ST_DIV;
            end
         end

         // Word number by reciprocal multiply
         bfns_pkg::ST_DIV: begin
            q_in     = IW'(prod >> bfns_pkg::RECIP_SH);
            state_in = bfns_pkg::ST_SPLIT;
         end

         // Offset, range check and first read
         bfns_pkg::ST_SPLIT: begin
            res_tested_in = 1'b0;
            res_found_in  = 1'b0;
            res_index_in  = '0;
            addr_in       = CW'(q_ff);
            off_in        = rem[OW-1:0];
            rd_addr       = q_ff[AW-1:0];
            state_in      = bfns_pkg::ST_DONE;
            case (cmd_ff)
               bfns_pkg::CMD_WRITE, bfns_pkg::CMD_TEST: begin
                  if (!neg_ff && (32'(op_ff) < NBITS) && in_range) begin
                     rd_en    = 1'b1;
                     state_in = bfns_pkg::ST_WORD;
                  end
               end
               bfns_pkg::CMD_FIND: begin
                  if (in_range) begin
                     rd_en    = 1'b1;
                     state_in = bfns_pkg::ST_WORD;
                  end
               end
               default: begin
                  state_in = bfns_pkg::ST_DONE;
               end
            endcase
         end

         // One stored word per cycle
         bfns_pkg::ST_WORD: begin
            state_in = bfns_pkg::ST_DONE;
            case (cmd_ff)
               bfns_pkg::CMD_WRITE: begin
                  wr_en   = 1'b1;
                  wr_data = val_ff ? (rd_data_ff | bit_mask) : (rd_data_ff & ~bit_mask);
               end
               bfns_pkg::CMD_TEST: begin
                  res_tested_in = rd_data_ff[off_ff];
               end
               bfns_pkg::CMD_FIND: begin
                  if (scan_hit) begin
                     res_found_in = 1'b1;
                     res_index_in = FW'(addr_ff) * WB_LOW + FW'(scan_pos);
                  end else if (addr_ff != LAST_WORD) begin
                     addr_in  = addr_nx;
                     off_in   = '0;
                     rd_en    = 1'b1;
                     rd_addr  = addr_nx[AW-1:0];
                     state_in = bfns_pkg::ST_WORD;
                  end
               end
               default: begin
                  state_in = bfns_pkg::ST_DONE;
               end
            endcase
         end

         // Hand the result to the output register once it is free
         bfns_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_tested_in = res_tested_ff;
               rsp_found_in  = res_found_ff;
               rsp_index_in  = res_index_ff;
               state_in      = bfns_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = bfns_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tested_bit  = rsp_tested_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_found_index = rsp_index_ff;

endmodule

// ----- sv/bfns_scan.sv -----
`timescale 1ns / 1ps

module bfns_scan #(
   parameter int WORD_BITS = 32,
   parameter int OW        = 5
) (
   input  logic [WORD_BITS-1:0] scan_word,
   input  logic [OW-1:0]        scan_from,
   output logic                 scan_hit,
   output logic [OW-1:0]        scan_pos
);

   logic [WORD_BITS-1:0] masked;
   logic [WORD_BITS-1:0] lowest;

   // Drop bits below the start offset, then isolate the lowest set bit
   assign masked   = scan_word & ({WORD_BITS{1'b1}} << scan_from);
   assign lowest   = masked & (~masked + {{(WORD_BITS-1){1'b0}}, 1'b1});
   assign scan_hit = |masked;

   // Encode the one-hot lowest bit into its position
   always_comb begin
      scan_pos = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (lowest[i]) begin
            scan_pos = scan_pos | OW'(i);
         end
      end
   end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

   localparam int NBITS = 1024;
   localparam int NB_W = $clog2(NBITS);
   localparam logic [bfns_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int HOLD_LEN = 300;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct packed {
      logic [bfns_pkg::CMD_W-1:0]          cmd;
      logic signed [bfns_pkg::INDEX_W-1:0] idx;
      logic                                val;
   } bit_cmd_type;

   typedef struct packed {
      logic                         tested;
      logic                         found;
      logic [bfns_pkg::FOUND_W-1:0] pos;
   } bit_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [bfns_pkg::CMD_W-1:0] req_cmd = '0;
   logic signed [bfns_pkg::INDEX_W-1:0] req_bit_index = '0;
   logic req_bit_value = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_tested_bit;
   logic rsp_found;
   logic [bfns_pkg::FOUND_W-1:0] rsp_found_index;

   // Shadow copy of the bit vector and the traffic queues
   logic [NBITS-1:0] bit_map = '0;
   bit_cmd_type pending_cmds[$];
   bit_rsp_type expected_rsps[$];
   bit_cmd_type next_cmd;
   bit_rsp_type want;
   logic req_fire = 1'b0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   logic hold_on = 1'b0;
   int hold_count = 0;
   int quiet_cycles = 0;
   int fail_count = 0;

   bitset_find_next_set dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_bit_index(req_bit_index),
      .req_bit_value(req_bit_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_tested_bit(rsp_tested_bit),
      .rsp_found(rsp_found),
      .rsp_found_index(rsp_found_index)
   );

   always #1 clock = ~clock;

   // Apply one command to the shadow vector and return the word it answers with
   function automatic bit_rsp_type apply_cmd(input bit_cmd_type c);
      bit_rsp_type r;
      int pos;
      int p;
      r = '0;
      pos = c.idx;
      case (c.cmd)
         bfns_pkg::CMD_WRITE: begin
            if (pos >= 0 && pos < NBITS) bit_map[NB_W'(pos)] = c.val;
         end
         bfns_pkg::CMD_TEST: begin
            if (pos >= 0 && pos < NBITS) r.tested = bit_map[NB_W'(pos)];
         end
         bfns_pkg::CMD_FIND: begin
            // any negative index scans from bit zero
            for (p = (pos < 0) ? 0 : pos + 1; p < NBITS; p++) begin
               if (bit_map[NB_W'(p)]) begin
                  r.found = 1'b1;
                  r.pos = bfns_pkg::FOUND_W'(p);
                  break;
               end
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // Mostly in-range commands; a few negative indexes and unused codes
   function automatic bit_cmd_type random_cmd(input int set_pct);
      bit_cmd_type c;
      int pick;
      pick = $urandom_range(99);
      if (pick < 40) c.cmd = bfns_pkg::CMD_WRITE;
      else if (pick < 65) c.cmd = bfns_pkg::CMD_TEST;
      else if (pick < 95) c.cmd = bfns_pkg::CMD_FIND;
      else c.cmd = CMD_UNUSED;
      pick = $urandom_range(99);
      if (pick < 88) c.idx = bfns_pkg::INDEX_W'($urandom_range(NBITS - 1));
      else if (pick < 94) c.idx = -11'sd1;
      else c.idx = bfns_pkg::INDEX_W'($urandom_range(2047, 1024));
      if (c.cmd == bfns_pkg::CMD_WRITE) c.val = ($urandom_range(99) < set_pct);
      else c.val = 1'($urandom_range(1));
      return c;
   endfunction

   task automatic add_cmd(input logic [bfns_pkg::CMD_W-1:0] cmd, input int idx,
                          input logic val);
      bit_cmd_type c;
      c.cmd = cmd;
      c.idx = bfns_pkg::INDEX_W'(idx);
      c.val = val;
      pending_cmds.push_back(c);
   endtask

   // Wait until every queued word is sent and every answer is back
   task automatic drain();
      do @(posedge clock);
      while (pending_cmds.size() != 0 || req_valid || expected_rsps.size() != 0);
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input int set_pct,
                            input int count);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) pending_cmds.push_back(random_cmd(set_pct));
      drain();
   endtask

   // Drive request words at the falling edge; hold until accepted
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_cmd = pending_cmds.pop_front();
            req_valid <= 1'b1;
            req_cmd <= next_cmd.cmd;
            req_bit_index <= next_cmd.idx;
            req_bit_value <= next_cmd.val;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall the response side at random, or hold it off for a long stretch
   always @(negedge clock) begin
      if (hold_on && hold_count < HOLD_LEN) begin
         hold_count <= hold_count + 1;
         rsp_stall <= 1'b1;
      end else begin
         if (!hold_on) hold_count <= 0;
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Check accepted responses, then predict for accepted requests
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("response word with nothing expected");
            fail_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_tested_bit !== want.tested) begin
               $error("tested_bit: expected %0d, got %0d", want.tested, rsp_tested_bit);
               fail_count++;
            end
            if (rsp_found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_found);
               fail_count++;
            end
            if (rsp_found_index !== want.pos) begin
               $error("found_index: expected %0d, got %0d", want.pos, rsp_found_index);
               fail_count++;
            end
         end
      end
      if (!reset && req_valid && !req_stall)
         expected_rsps.push_back(
            apply_cmd(bit_cmd_type'({req_cmd, req_bit_index, req_bit_value})));
      req_fire <= !reset && req_valid && !req_stall;
   end

   // Abort when neither side moves a word for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed: range ends, word boundaries, negative and unused cases
      add_cmd(bfns_pkg::CMD_WRITE, 0, 1'b1);
      add_cmd(bfns_pkg::CMD_WRITE, NBITS - 1, 1'b1);
      add_cmd(bfns_pkg::CMD_TEST, 0, 1'b0);
      add_cmd(bfns_pkg::CMD_TEST, NBITS - 1, 1'b0);
      add_cmd(bfns_pkg::CMD_TEST, 1, 1'b1);
      add_cmd(bfns_pkg::CMD_FIND, -1, 1'b0);
      add_cmd(bfns_pkg::CMD_FIND, 0, 1'b0);
      add_cmd(bfns_pkg::CMD_FIND, NBITS - 2, 1'b0);
      add_cmd(bfns_pkg::CMD_FIND, NBITS - 1, 1'b0);
      add_cmd(bfns_pkg::CMD_WRITE, 31, 1'b1);
      add_cmd(bfns_pkg::CMD_WRITE, 32, 1'b1);
      add_cmd(bfns_pkg::CMD_FIND, 0, 1'b1);
      add_cmd(bfns_pkg::CMD_FIND, 31, 1'b0);
      add_cmd(bfns_pkg::CMD_FIND, 32, 1'b0);
      add_cmd(bfns_pkg::CMD_FIND, -1024, 1'b0);
      add_cmd(bfns_pkg::CMD_WRITE, -1, 1'b1);
      add_cmd(bfns_pkg::CMD_TEST, -1, 1'b1);
      add_cmd(bfns_pkg::CMD_TEST, -1024, 1'b0);
      add_cmd(CMD_UNUSED, 5, 1'b1);
      add_cmd(bfns_pkg::CMD_WRITE, 0, 1'b0);
      add_cmd(bfns_pkg::CMD_FIND, -1, 1'b0);
      add_cmd(bfns_pkg::CMD_WRITE, NBITS - 1, 1'b0);
      add_cmd(bfns_pkg::CMD_FIND, 32, 1'b0);
      add_cmd(bfns_pkg::CMD_TEST, NBITS - 1, 1'b0);
      drain();

      run_phase(0, 0, 50, 150);
      run_phase(87, 0, 30, 110);
      run_phase(0, 87, 10, 110);
      run_phase(36, 36, 10, 110);

      // Hold the response side off while requests keep coming
      hold_on = 1'b1;
      run_phase(0, 0, 50, 80);
      hold_on = 1'b0;

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
